@@ hdl/subset_vertex_index_compaction_assert.svh @@
// Assertion macros used by the main RTL file. Clock i_clk, reset i_rst_n.
`ifndef SUBSET_VERTEX_INDEX_COMPACTION_ASSERT_SVH
`define SUBSET_VERTEX_INDEX_COMPACTION_ASSERT_SVH

// Same-cycle implication
`define SVIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SVIC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/svic_pkg.sv @@
`timescale 1ns / 1ps

package svic_pkg;

    // Item field widths
    localparam int OP_W    = 3;
    localparam int FACE_W  = 12;
    localparam int POS_W   = 14;
    localparam int VIDX_W  = 12;
    localparam int VCNT_W  = 5;
    localparam int NIDX_W  = 12;
    localparam int STAT_W  = 2;

    // Subset generation tag kept with each remap entry
    localparam int EPOCH_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_WRITE  = 3'd2,
        OP_SUBSET = 3'd3,
        OP_SELECT = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FACE = 2'd1,
        ST_IDX  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FACE,
        S_CORNER,
        S_EMIT
    } t_state;

endpackage

@@ hdl/subset_vertex_index_compaction.sv @@
// Ops 0 to 3 pass an accept step (S_IDLE) and an execute step (S_EXEC); an error result is registered.
// Op 4 reads the face table, then per corner the corner store and the remap entry, and emits with the
// remap read-modify-write on registered-read memories; no new item is taken until the face is done.
// Reset: synchronous, active low; afterwards a remap clearing pass over all MAX_VERTICES entries
// runs before the first item is taken. The same pass runs again on every 63rd op 0 or op 3.
`timescale 1ns / 1ps

module subset_vertex_index_compaction #(
    parameter int MAX_FACES        = 4096,
    parameter int MAX_CORNERS      = 16384,
    parameter int MAX_VERTICES     = 4096,
    parameter int MAX_FACE_CORNERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [svic_pkg::OP_W-1:0]     i_op,
    input  logic [svic_pkg::FACE_W-1:0]   i_face_index,
    input  logic [svic_pkg::POS_W-1:0]    i_position,
    input  logic [svic_pkg::VIDX_W-1:0]   i_vertex_index,
    input  logic [svic_pkg::VCNT_W-1:0]   i_vertex_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [svic_pkg::NIDX_W-1:0]   o_new_index,
    output logic [svic_pkg::VIDX_W-1:0]   o_original_index,
    output logic                          o_newly_added,
    output logic [svic_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last
);

    import svic_pkg::*;

    localparam int FACE_AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FCNT_W  = $clog2(MAX_FACES + 1);
    localparam int OFF_W   = $clog2(MAX_CORNERS + 1);
    localparam int CORN_AW = $clog2(MAX_CORNERS);
    localparam int VERT_AW = $clog2(MAX_VERTICES);
    localparam int NC_W    = $clog2(MAX_VERTICES + 1);
    localparam int FM_W    = OFF_W + VCNT_W;
    localparam int RM_W    = EPOCH_W + NIDX_W;

    // Control state
    t_state              r_state, n_state;
    logic [FCNT_W-1:0]   r_faces_loaded, n_faces_loaded;
    logic [OFF_W-1:0]    r_run, n_run;
    logic [NC_W-1:0]     r_next, n_next;
    logic [EPOCH_W-1:0]  r_epoch, n_epoch;
    logic [VERT_AW-1:0]  r_clr, n_clr;
    logic                r_out_valid;

    // Item and walk registers
    t_op                 r_op;
    logic [FACE_W-1:0]   r_face;
    logic [POS_W-1:0]    r_pos;
    logic [VIDX_W-1:0]   r_vidx;
    logic [VCNT_W-1:0]   r_vcnt;
    logic [OFF_W-1:0]    r_slot, n_slot;
    logic [VCNT_W-1:0]   r_left, n_left;
    logic [VIDX_W-1:0]   r_orig, n_orig;

    // Output register
    logic [NIDX_W-1:0]   r_ni;
    logic [VIDX_W-1:0]   r_oi;
    logic                r_added;
    t_status             r_status;
    logic                r_last;

    logic                out_free, out_load;
    logic [NIDX_W-1:0]   lo_ni;
    logic [VIDX_W-1:0]   lo_oi;
    logic                lo_added;
    t_status             lo_status;
    logic                lo_last;
    logic                in_acc;

    // Memory ports
    logic                fm_we, fm_re;
    logic [FACE_AW-1:0]  fm_waddr, fm_raddr;
    logic [FM_W-1:0]     fm_wdata, fm_rdata;
    logic                cs_we, cs_re;
    logic [CORN_AW-1:0]  cs_waddr, cs_raddr;
    logic [VIDX_W-1:0]   cs_wdata, cs_rdata;
    logic                rm_we, rm_re;
    logic [VERT_AW-1:0]  rm_waddr, rm_raddr;
    logic [RM_W-1:0]     rm_wdata, rm_rdata;

    logic [OFF_W:0]      append_end;
    logic [OFF_W-1:0]    fm_start;
    logic [VCNT_W-1:0]   fm_cnt;
    logic [EPOCH_W-1:0]  rm_epoch;
    logic [NIDX_W-1:0]   rm_ni;
    logic [OFF_W-1:0]    slot_inc;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign append_end = {1'b0, r_run} + (OFF_W + 1)'(r_vcnt);
    assign {fm_start, fm_cnt}  = fm_rdata;
    assign {rm_epoch, rm_ni}   = rm_rdata;
    assign slot_inc = r_slot + OFF_W'(1);

    // Face table: start offset and corner count
    svic_ram #(.WIDTH(FM_W), .DEPTH(MAX_FACES)) u_face_mem (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_re    (fm_re),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    // Face-vertex index store
    svic_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_CORNERS)) u_corner_mem (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_re    (cs_re),
        .i_raddr (cs_raddr),
        .o_rdata (cs_rdata)
    );

    // Remap table: entry is valid when its epoch matches the current subset
    svic_ram #(.WIDTH(RM_W), .DEPTH(MAX_VERTICES)) u_remap_mem (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_re    (rm_re),
        .i_raddr (rm_raddr),
        .o_rdata (rm_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_faces_loaded <= '0;
            r_run          <= '0;
            r_next         <= '0;
            r_epoch        <= EPOCH_W'(1);
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_faces_loaded <= n_faces_loaded;
            r_run          <= n_run;
            r_next         <= n_next;
            r_epoch        <= n_epoch;
            r_clr          <= n_clr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= t_op'(i_op);
            r_face <= i_face_index;
            r_pos  <= i_position;
            r_vidx <= i_vertex_index;
            r_vcnt <= i_vertex_count;
        end
        r_slot <= n_slot;
        r_left <= n_left;
        r_orig <= n_orig;
        if (out_load) begin
            r_ni     <= lo_ni;
            r_oi     <= lo_oi;
            r_added  <= lo_added;
            r_status <= lo_status;
            r_last   <= lo_last;
        end
    end

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_faces_loaded = r_faces_loaded;
        n_run          = r_run;
        n_next         = r_next;
        n_epoch        = r_epoch;
        n_clr          = r_clr;
        n_slot         = r_slot;
        n_left         = r_left;
        n_orig         = r_orig;

        out_load  = 1'b0;
        lo_ni     = '0;
        lo_oi     = '0;
        lo_added  = 1'b0;
        lo_status = ST_OK;
        lo_last   = 1'b1;

        fm_we    = 1'b0;
        fm_waddr = FACE_AW'(r_faces_loaded);
        fm_wdata = {r_run, r_vcnt};
        fm_re    = 1'b0;
        fm_raddr = FACE_AW'(r_face);
        cs_we    = 1'b0;
        cs_waddr = CORN_AW'(r_pos);
        cs_wdata = r_vidx;
        cs_re    = 1'b0;
        cs_raddr = CORN_AW'(r_slot);
        rm_we    = 1'b0;
        rm_waddr = VERT_AW'(r_orig);
        rm_wdata = {r_epoch, NIDX_W'(r_next)};
        rm_re    = 1'b0;
        rm_raddr = VERT_AW'(cs_rdata);

        case (r_state)
            // Sweep the remap table to epoch zero
            S_CLEAR: begin
                rm_we    = 1'b1;
                rm_waddr = r_clr;
                rm_wdata = '0;
                n_clr    = r_clr + VERT_AW'(1);
                if (r_clr == VERT_AW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_op)
                    OP_CLEAR, OP_SUBSET: begin
                        if (r_op == OP_CLEAR) begin
                            n_faces_loaded = '0;
                            n_run          = '0;
                        end
                        n_next = '0;
                        // Epoch wrap: rerun the sweep so no stale tag matches
                        if (r_epoch == '1) begin
                            n_epoch = EPOCH_W'(1);
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                            n_state = S_IDLE;
                        end
                    end
                    OP_APPEND: begin
                        if (32'(r_faces_loaded) >= MAX_FACES ||
                            32'(r_vcnt) > MAX_FACE_CORNERS ||
                            32'(append_end) > MAX_CORNERS) begin
                            if (out_free) begin
                                out_load  = 1'b1;
                                lo_status = ST_FULL;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            fm_we          = 1'b1;
                            n_faces_loaded = r_faces_loaded + FCNT_W'(1);
                            n_run          = append_end[OFF_W-1:0];
                            n_state        = S_IDLE;
                        end
                    end
                    OP_WRITE: begin
                        if (32'(r_pos) >= MAX_CORNERS || 32'(r_vidx) >= MAX_VERTICES) begin
                            if (out_free) begin
                                out_load  = 1'b1;
                                lo_status = ST_IDX;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            cs_we   = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    OP_SELECT: begin
                        if (32'(r_face) >= 32'(r_faces_loaded)) begin
                            if (out_free) begin
                                out_load  = 1'b1;
                                lo_status = ST_FACE;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            fm_re   = 1'b1;
                            n_state = S_FACE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Face entry read back: start the corner walk
            S_FACE: begin
                if (fm_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_slot   = fm_start;
                    n_left   = fm_cnt;
                    cs_re    = 1'b1;
                    cs_raddr = CORN_AW'(fm_start);
                    n_state  = S_CORNER;
                end
            end

            // Corner index read back: look up its remap entry
            S_CORNER: begin
                n_orig  = cs_rdata;
                rm_re   = 1'b1;
                n_state = S_EMIT;
            end

            // Resolve the corner, update remap, emit
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (32'(r_orig) >= MAX_VERTICES) begin
                        lo_status = ST_IDX;
                        n_state   = S_IDLE;
                    end else if (rm_epoch != r_epoch && 32'(r_next) >= MAX_VERTICES) begin
                        lo_status = ST_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        lo_oi   = r_orig;
                        lo_last = (r_left == VCNT_W'(1));
                        if (rm_epoch == r_epoch) begin
                            lo_ni = rm_ni;
                        end else begin
                            rm_we    = 1'b1;
                            lo_ni    = NIDX_W'(r_next);
                            lo_added = 1'b1;
                            n_next   = r_next + NC_W'(1);
                        end
                        if (r_left == VCNT_W'(1)) begin
                            n_state = S_IDLE;
                        end else begin
                            n_slot   = slot_inc;
                            n_left   = r_left - VCNT_W'(1);
                            cs_re    = 1'b1;
                            cs_raddr = CORN_AW'(slot_inc);
                            n_state  = S_CORNER;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_new_index      = r_ni;
    assign o_original_index = r_oi;
    assign o_newly_added    = r_added;
    assign o_status         = r_status;
    assign o_last           = r_last;

`include "subset_vertex_index_compaction_assert.svh"

    `SVIC_ASSERT_IMP(a_err_fields, (o_valid && o_status != ST_OK), (o_last && o_new_index == '0 && o_original_index == '0 && !o_newly_added), "error result with nonzero fields")
    `SVIC_ASSERT_NXT(a_alloc_step, (r_state == S_EMIT && rm_we), (r_next == $past(r_next) + NC_W'(1)), "compact index not advanced on allocation")
    `SVIC_ASSERT_IMP(a_clear_empty, (r_state == S_CLEAR), (r_next == '0 && !rm_re && !cs_re), "subset not empty during remap sweep")

endmodule

@@ hdl/svic_ram.sv @@
`timescale 1ns / 1ps

module svic_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import svic_pkg::*;

    localparam int MAX_FACES        = 4096;
    localparam int MAX_CORNERS      = 16384;
    localparam int MAX_VERTICES     = 4096;
    localparam int MAX_FACE_CORNERS = 16;

    localparam int FACE_TOP = (1 << FACE_W) - 1;
    localparam int POS_TOP  = (1 << POS_W) - 1;
    localparam int VTX_TOP  = (1 << VIDX_W) - 1;
    localparam int CNT_TOP  = (1 << VCNT_W) - 1;

    // Opcode outside the defined set; the block must drop it silently
    localparam logic [OP_W-1:0] OP_UNUSED_TOP = '1;

    localparam int HALF_PERIOD  = 4;
    localparam int DRAIN_CYCLES = 64;
    localparam int RUN_LIMIT    = 1000000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [FACE_W-1:0] face;
        logic [POS_W-1:0]  pos;
        logic [VIDX_W-1:0] vidx;
        logic [VCNT_W-1:0] cnt;
    } t_mesh_cmd;

    typedef struct packed {
        logic [NIDX_W-1:0] new_index;
        logic [VIDX_W-1:0] original_index;
        logic              newly_added;
        t_status           status;
        logic              last;
    } t_corner_out;

    // Mirror of the mesh tables and the subset remap; predicts corner items per command
    class compaction_board;
        bit [14:0]        face_start   [MAX_FACES];
        bit [VCNT_W-1:0]  face_corners [MAX_FACES];
        int               faces_loaded;
        int               running_offset;
        bit [VIDX_W-1:0]  corner_store [MAX_CORNERS];
        bit [NIDX_W-1:0]  remap_table  [MAX_VERTICES];
        bit               remap_valid  [MAX_VERTICES];
        int               next_compact;
        t_corner_out      expected_corners [$];
        int               fail_count;
        int               checked_count;

        function void start_subset();
            foreach (remap_valid[v]) remap_valid[v] = 1'b0;
            next_compact = 0;
        endfunction

        // Error items carry only the status and the last flag
        function void expect_error(t_status st);
            t_corner_out r;
            r = '0;
            r.status = st;
            r.last   = 1'b1;
            expected_corners = {expected_corners, r};
        endfunction

        function void note_command(t_mesh_cmd c);
            int base;
            int n;
            int orig;
            int i;
            bit stop;
            t_corner_out r;
            case (c.op)
                OP_CLEAR: begin
                    faces_loaded   = 0;
                    running_offset = 0;
                    start_subset();
                end
                OP_APPEND: begin
                    if (faces_loaded >= MAX_FACES || c.cnt > MAX_FACE_CORNERS ||
                        running_offset + c.cnt > MAX_CORNERS) begin
                        expect_error(ST_FULL);
                    end else begin
                        face_start[faces_loaded]   = running_offset[14:0];
                        face_corners[faces_loaded] = c.cnt;
                        faces_loaded++;
                        running_offset += c.cnt;
                    end
                end
                OP_WRITE: begin
                    if (c.pos >= MAX_CORNERS || c.vidx >= MAX_VERTICES)
                        expect_error(ST_IDX);
                    else
                        corner_store[c.pos] = c.vidx;
                end
                OP_SUBSET: start_subset();
                OP_SELECT: begin
                    if (c.face >= faces_loaded) begin
                        expect_error(ST_FACE);
                    end else begin
                        base = face_start[c.face];
                        n    = face_corners[c.face];
                        stop = 1'b0;
                        for (i = 0; i < n && !stop; i++) begin
                            orig = (base + i < MAX_CORNERS) ? corner_store[base + i] : 0;
                            r = '0;
                            if (orig >= MAX_VERTICES) begin
                                expect_error(ST_IDX);
                                stop = 1'b1;
                            end else if (!remap_valid[orig] && next_compact >= MAX_VERTICES) begin
                                expect_error(ST_FULL);
                                stop = 1'b1;
                            end else begin
                                // first sighting in this subset hands out the next compact index
                                if (!remap_valid[orig]) begin
                                    remap_table[orig] = next_compact[NIDX_W-1:0];
                                    remap_valid[orig] = 1'b1;
                                    next_compact++;
                                    r.newly_added = 1'b1;
                                end
                                r.new_index      = remap_table[orig];
                                r.original_index = orig[VIDX_W-1:0];
                                r.status         = ST_OK;
                                r.last           = (i + 1 == n);
                                expected_corners = {expected_corners, r};
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_corner(t_corner_out got);
            t_corner_out want;
            if (expected_corners.size() == 0) begin
                $error("unexpected corner item: nothing pending");
                fail_count++;
                return;
            end
            want = expected_corners.pop_front();
            checked_count++;
            if (got.new_index !== want.new_index) begin
                $error("new_index: expected %0d, got %0d", want.new_index, got.new_index);
                fail_count++;
            end
            if (got.original_index !== want.original_index) begin
                $error("original_index: expected %0d, got %0d",
                       want.original_index, got.original_index);
                fail_count++;
            end
            if (got.newly_added !== want.newly_added) begin
                $error("newly_added: expected %0d, got %0d", want.newly_added, got.newly_added);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_corners.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_op;
    logic [FACE_W-1:0]   i_face_index;
    logic [POS_W-1:0]    i_position;
    logic [VIDX_W-1:0]   i_vertex_index;
    logic [VCNT_W-1:0]   i_vertex_count;
    logic                o_valid;
    logic                i_stall;
    logic [NIDX_W-1:0]   o_new_index;
    logic [VIDX_W-1:0]   o_original_index;
    logic                o_newly_added;
    logic [STAT_W-1:0]   o_status;
    logic                o_last;

    compaction_board board;
    bit              slot_written [MAX_CORNERS];
    int              src_idle_pct;
    int              sink_stall_pct;
    int              vtx_hi;
    int              items_sent;
    int              cycle_count;

    subset_vertex_index_compaction dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_op             (i_op),
        .i_face_index     (i_face_index),
        .i_position       (i_position),
        .i_vertex_index   (i_vertex_index),
        .i_vertex_count   (i_vertex_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_new_index      (o_new_index),
        .o_original_index (o_original_index),
        .o_newly_added    (o_newly_added),
        .o_status         (o_status),
        .o_last           (o_last)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Result side: check accepted corner items, then pick the next stall
    always @(posedge i_clk) begin : corner_monitor
        t_corner_out got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.new_index      = o_new_index;
            got.original_index = o_original_index;
            got.newly_added    = o_newly_added;
            got.status         = t_status'(o_status);
            got.last           = o_last;
            board.check_corner(got);
        end
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Drive one command item and hold it until the block takes it
    task automatic send(input logic [OP_W-1:0] op, input int face, input int pos,
                        input int vidx, input int cnt);
        t_mesh_cmd c;
        c.op   = op;
        c.face = face[FACE_W-1:0];
        c.pos  = pos[POS_W-1:0];
        c.vidx = vidx[VIDX_W-1:0];
        c.cnt  = cnt[VCNT_W-1:0];
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= c.op;
        i_face_index   <= c.face;
        i_position     <= c.pos;
        i_vertex_index <= c.vidx;
        i_vertex_count <= c.cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_command(c);
        if (op <= OP_SELECT) items_sent++;
    endtask

    task automatic write_slot(input int pos, input int vidx);
        send(OP_WRITE, $urandom, pos, vidx, $urandom);
        slot_written[pos] = 1'b1;
    endtask

    // A face may only be selected once every one of its slots holds a value
    function automatic bit face_ready(int f);
        for (int s = board.face_start[f]; s < board.face_start[f] + board.face_corners[f]; s++)
            if (!slot_written[s]) return 1'b0;
        return 1'b1;
    endfunction

    // Append a face and fill its corners, mostly from the current vertex pool
    task automatic build_face(input int cnt);
        int base;
        int prev_loaded;
        base        = board.running_offset;
        prev_loaded = board.faces_loaded;
        send(OP_APPEND, $urandom, $urandom, $urandom, cnt);
        if (board.faces_loaded == prev_loaded + 1) begin
            for (int s = base; s < base + cnt; s++)
                write_slot(s, ($urandom_range(3) == 0) ? $urandom_range(VTX_TOP)
                                                      : $urandom_range(vtx_hi));
        end
    endtask

    // Mostly a loaded face with all corners written, now and then one beyond the loaded faces
    task automatic select_face();
        int f;
        bit found;
        found = 1'b0;
        for (int t = 0; t < 8 && !found && board.faces_loaded > 0; t++) begin
            f = $urandom_range(board.faces_loaded - 1);
            found = face_ready(f);
        end
        if (board.faces_loaded < MAX_FACES && (!found || $urandom_range(99) < 12)) begin
            f = $urandom_range(FACE_TOP, board.faces_loaded);
            found = 1'b1;
        end
        if (found) send(OP_SELECT, f, $urandom, $urandom, $urandom);
    endtask

    task automatic pick_vertex_pool();
        case ($urandom_range(2))
            0:       vtx_hi = 7;
            1:       vtx_hi = 63;
            default: vtx_hi = VTX_TOP;
        endcase
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        int pick;
        int k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                pick_vertex_pool();
            end else if (pick < 20) begin
                k = $urandom_range(99);
                if (k < 5)
                    build_face($urandom_range(CNT_TOP, MAX_FACE_CORNERS + 1));
                else if (k < 25)
                    build_face($urandom_range(MAX_FACE_CORNERS));
                else
                    build_face($urandom_range(6, 3));
            end else if (pick < 26) begin
                write_slot($urandom_range(POS_TOP), $urandom_range(VTX_TOP));
            end else if (pick < 40) begin
                send(OP_SUBSET, $urandom, $urandom, $urandom, $urandom);
                pick_vertex_pool();
            end else if (pick < 43) begin
                send(OP_W'($urandom_range(OP_UNUSED_TOP, OP_SELECT + 1)),
                     $urandom, $urandom, $urandom, $urandom);
            end else begin
                select_face();
            end
        end
    endtask

    // Short hand-picked sequence: extremes, every op, the corner cases
    task automatic directed_checks();
        send(OP_SELECT, 0, $urandom, $urandom, $urandom);          // no faces yet
        send(OP_APPEND, $urandom, $urandom, $urandom, 3);
        write_slot(0, 0);
        write_slot(1, VTX_TOP);
        write_slot(2, 0);                                          // repeat inside one face
        send(OP_APPEND, $urandom, $urandom, $urandom, 0);          // empty face
        send(OP_APPEND, $urandom, $urandom, $urandom, MAX_FACE_CORNERS + 1);
        send(OP_APPEND, $urandom, $urandom, $urandom, CNT_TOP);
        send(OP_APPEND, $urandom, $urandom, $urandom, 4);
        write_slot(3, VTX_TOP);
        write_slot(4, 0);
        write_slot(5, 1 << (VIDX_W - 1));
        write_slot(6, VTX_TOP);
        write_slot(POS_TOP, VTX_TOP);
        send(OP_SUBSET, $urandom, $urandom, $urandom, $urandom);
        send(OP_SELECT, 0, $urandom, $urandom, $urandom);
        send(OP_SELECT, 1, $urandom, $urandom, $urandom);
        send(OP_SELECT, 2, $urandom, $urandom, $urandom);          // shares vertices with face 0
        send(OP_SELECT, 0, $urandom, $urandom, $urandom);          // all corners already mapped
        send(OP_SELECT, FACE_TOP, $urandom, $urandom, $urandom);
        send(OP_UNUSED_TOP, $urandom, $urandom, $urandom, $urandom);
        send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        send(OP_SELECT, 0, $urandom, $urandom, $urandom);          // gone after clear
    endtask

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        board          = new();
        items_sent     = 0;
        vtx_hi         = 63;
        src_idle_pct   = 16;
        sink_stall_pct = 61;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_op           <= OP_CLEAR;
        i_face_index   <= '0;
        i_position     <= '0;
        i_vertex_index <= '0;
        i_vertex_count <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();
        random_traffic(150);

        src_idle_pct   = 61;
        sink_stall_pct = 16;
        random_traffic(150);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_traffic(150);
        i_valid <= 1'b0;

        // let the last faces drain, then watch for stray items
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d corner items never arrived", board.pending());
            board.fail_count++;
        end

        $display("Covered %0d command items: clears, face appends, corner writes, subset starts",
                 items_sent);
        $display("and face selects incl. error cases; %0d corner items compared, %0d mismatches.",
                 board.checked_count, board.fail_count);
        if (board.fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/svic_pkg.sv
hdl/svic_ram.sv
hdl/subset_vertex_index_compaction.sv
bench/tb_top.sv
